/* rtl/hkv_pkg.sv */
// ----------------------------------------------------------------------------
// hkv_pkg
// Shared widths, constants, codes and types for the Hall key velocity tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package hkv_pkg;

   // field widths
   localparam int KIND_W   = 2;
   localparam int KEY_W    = 5;
   localparam int SAMPLE_W = 12;
   localparam int TIME_W   = 64;
   localparam int CENTER_W = 14;
   localparam int GAIN_W   = 13;
   localparam int DIST_W   = 16;
   localparam int LEVEL_W  = 8;

   // internal arithmetic widths
   localparam int OFFSET_W    = 14;   // |reading - center|
   localparam int PROD_W      = 20;   // gain * 100
   localparam int DIV_W       = 26;   // shared divider operand width
   localparam int DIGIT_BITS  = 2;    // quotient bits per divider cycle
   localparam int DIGIT_CNT_W = 4;
   localparam int LEVEL_X_W   = 9;    // distance above base, below saturation
   localparam int LEVEL_PRE   = 4;    // divide by 16 ahead of the divide by 25
   localparam int LEVEL_Y_W   = LEVEL_X_W + LEVEL_W;
   localparam int LEVEL_Z_W   = LEVEL_Y_W - LEVEL_PRE;
   localparam int LEVEL_P_W   = 2 * LEVEL_Z_W;

   // divider digit counts: distance quotient 20 bits, speed quotient 26 bits
   localparam logic [DIGIT_CNT_W-1:0] DIGITS_DIST  = 4'd10;
   localparam logic [DIGIT_CNT_W-1:0] DIGITS_SPEED = 4'd13;

   // scale factors and limits
   localparam logic [PROD_W-1:0]    GAIN_SCALE  = 20'd100;
   localparam logic [DIV_W-1:0]     SPEED_SCALE = 26'd1000;
   localparam logic [DIST_W-1:0]    DIST_MAX    = 16'hFFFF;
   localparam logic [DIST_W-1:0]    LEVEL_BASE  = 16'd100;
   localparam logic [DIST_W-1:0]    LEVEL_SAT   = 16'd402;
   localparam logic [LEVEL_W-1:0]   LEVEL_MAX   = 8'd255;
   localparam logic [LEVEL_P_W-1:0] RECIP_25    = 26'd5243;
   localparam int                   RECIP_SHIFT = 17;

   // configuration port
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;
   localparam int CFG_W  = 16;
   localparam logic [DIST_W-1:0] PRESS_RESET   = 16'd250;
   localparam logic [DIST_W-1:0] RELEASE_RESET = 16'd300;
   localparam logic REG_PRESS   = 1'b0;
   localparam logic REG_RELEASE = 1'b1;

   // request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_FRAME  = 2'd0,
      KIND_SAMPLE = 2'd1,
      KIND_LOAD   = 2'd2
   } kind_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DIST,
      ST_JUDGE,
      ST_PREP,
      ST_SPEED,
      ST_FINISH
   } state_type;

   // divider start control
   typedef struct packed {
      logic                   start;
      logic [DIGIT_CNT_W-1:0] digits;
   } div_ctl_type;

endpackage

`default_nettype wire

/* rtl/hkv_intf.sv */
// ----------------------------------------------------------------------------
// hkv_intf
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface hkv_req_intf;
   logic                                valid;
   logic                                ready;
   logic [hkv_pkg::KIND_W-1:0]          kind;
   logic [hkv_pkg::KEY_W-1:0]           key;
   logic [hkv_pkg::SAMPLE_W-1:0]        sample_value;
   logic [hkv_pkg::TIME_W-1:0]          timestamp;
   logic signed [hkv_pkg::CENTER_W-1:0] center_value;
   logic [hkv_pkg::GAIN_W-1:0]          field_gain;

   modport source (output valid, kind, key, sample_value, timestamp, center_value,
                   field_gain, input ready);
   modport sink (input valid, kind, key, sample_value, timestamp, center_value,
                 field_gain, output ready);
endinterface

interface hkv_rsp_intf;
   logic                        valid;
   logic                        ready;
   logic [hkv_pkg::KEY_W-1:0]   out_key;
   logic                        is_pressed;
   logic                        event_res;
   logic [hkv_pkg::DIST_W-1:0]  speed;
   logic [hkv_pkg::DIST_W-1:0]  distance;
   logic [hkv_pkg::LEVEL_W-1:0] analog_level;

   modport source (output valid, out_key, is_pressed, event_res, speed, distance,
                   analog_level, input ready);
   modport sink (input valid, out_key, is_pressed, event_res, speed, distance,
                 analog_level, output ready);
endinterface

`default_nettype wire

/* rtl/hkv_div.sv */
// ----------------------------------------------------------------------------
// hkv_div
// Shared restoring divider, two quotient bits per cycle. The dividend shifts
// out of the top of a shift register into the partial remainder while the
// quotient shifts in at the bottom. done pulses as the last digit is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hkv_div (
   input  logic                        clock,
   input  logic                        reset,
   input  hkv_pkg::div_ctl_type        ctl,
   input  logic [hkv_pkg::DIV_W-1:0]   dividend,
   input  logic [hkv_pkg::DIV_W-1:0]   divisor,
   output logic                        done,
   output logic [hkv_pkg::DIV_W-1:0]   quotient
);
   import hkv_pkg::*;

   logic [DIV_W:0]         rem_ff, rem_in;
   logic [DIV_W-1:0]       num_ff, num_in;
   logic [DIV_W-1:0]       quo_ff, quo_in;
   logic [DIV_W-1:0]       div_ff;
   logic [DIGIT_CNT_W-1:0] cnt_ff;
   logic                   busy_ff;
   logic                   done_ff;

   // one digit: shift in two dividend bits, trial subtract each
   always_comb begin
      rem_in = rem_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      for (int i = 0; i < DIGIT_BITS; i++) begin
         rem_in = {rem_in[DIV_W-1:0], num_in[DIV_W-1]};
         num_in = {num_in[DIV_W-2:0], 1'b0};
         if (rem_in >= {1'b0, div_ff}) begin
            rem_in = rem_in - {1'b0, div_ff};
            quo_in = {quo_in[DIV_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_in[DIV_W-2:0], 1'b0};
         end
      end
   end

   // digit counter and completion
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= ctl.digits;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - DIGIT_CNT_W'(1);
            if (cnt_ff == DIGIT_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // operand shift registers
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         rem_ff <= '0;
         num_ff <= dividend;
         quo_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* rtl/hall_key_velocity_tracker.sv */
// ----------------------------------------------------------------------------
// hall_key_velocity_tracker
// Per-key Hall sensor press/release tracker with distance and velocity.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one request at a time: a frame tick (shifts the frame
//   time history, no response), a key sample, or a key baseline load (no
//   response). Requests for keys beyond KEY_COUNT and the unused kind are dropped.
//   rsp_chan returns one response per key sample: press state, event flag,
//   velocity, distance and a 0..255 analog level.
//   A sample runs the distance division and, on a press or release only, the
//   velocity division on the shared two-bit-per-cycle divider (10 digits for
//   the distance, 13 for the velocity). req_chan.ready is high only while no
//   request is in progress. The response sits in an output register; the next
//   request is taken while it waits, and a later sample holds in its last step
//   until it is taken. The user must write thresholds over the APB-style port
//   only while the block is idle; the block itself does not enforce it.
//   Reset is synchronous: thresholds return to 250 and 300, frame times and
//   all per-key state read as zero (one valid bit per key), no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module hall_key_velocity_tracker #(
   parameter int KEY_COUNT     = 32,
   parameter int HISTORY_DEPTH = 3
) (
   input  logic                        clock,
   input  logic                        reset,
   hkv_req_intf.sink                   req_chan,
   hkv_rsp_intf.source                 rsp_chan,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [hkv_pkg::ADDR_W-1:0]  paddr,
   input  logic [hkv_pkg::DATA_W-1:0]  pwdata,
   output logic [hkv_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import hkv_pkg::*;

   localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int HW = HISTORY_DEPTH * DIST_W;
   localparam int RW = 1 + CENTER_W + GAIN_W + DIST_W + HW;
   localparam int KEY_CMP_W = 8;
   localparam int DIST_PAD = DIV_W - PROD_W;

   // configuration registers
   logic [DIST_W-1:0] press_ff;
   logic [DIST_W-1:0] release_ff;

   // frame time history
   logic [TIME_W-1:0] now_time_ff;
   logic [TIME_W-1:0] past_ff [HISTORY_DEPTH];

   // per-key record store
   logic [RW-1:0]        mem [KEY_COUNT];
   logic [KEY_COUNT-1:0] key_valid_ff;
   logic [RW-1:0]        mem_q_ff;
   logic                 row_valid_ff;

   // sequencer
   state_type state_ff, state_in;
   logic      req_ready;
   logic      capture;
   logic      frame_shift;
   logic      mem_we;
   logic      out_load;
   logic      key_ok;

   // latched request
   logic [KEY_W-1:0]    key_ff;
   logic                is_load_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [CENTER_W-1:0] center_ld_ff;
   logic [GAIN_W-1:0]   gain_ld_ff;

   // datapath registers
   logic              zero_ff;
   logic [DIST_W-1:0] dist_ff;
   logic              event_ff;
   logic              pressed_new_ff;
   logic [DIST_W-1:0] delta_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic [DIST_W-1:0] speed_ff;
   logic              intv_zero_ff;
   logic              intv_big_ff;
   logic [DIV_W-1:0]  intv_lo_ff;

   // output register
   logic               rsp_valid_ff;
   logic [KEY_W-1:0]   out_key_ff;
   logic               is_pressed_ff;
   logic               event_res_ff;
   logic [DIST_W-1:0]  speed_out_ff;
   logic [DIST_W-1:0]  dist_out_ff;
   logic [LEVEL_W-1:0] level_out_ff;

   // combinational datapath
   logic [RW-1:0]       row;
   logic                row_pressed;
   logic [CENTER_W-1:0] row_center;
   logic [GAIN_W-1:0]   row_gain;
   logic [DIST_W-1:0]   row_speed;
   logic [HW-1:0]       row_hist;
   logic [DIST_W-1:0]   oldest;
   logic signed [CENTER_W:0] diff;
   logic [OFFSET_W-1:0] offset;
   logic [PROD_W-1:0]   gain_prod;
   logic [DIST_W-1:0]   dist_q;
   logic                event_now;
   logic [DIST_W-1:0]   delta_now;
   logic [DIST_W-1:0]   level_x;
   logic [LEVEL_Y_W-1:0] level_y;
   logic [LEVEL_Z_W-1:0] level_z;
   logic [LEVEL_P_W-1:0] level_p;
   logic [LEVEL_W-1:0]  level_now;
   logic [TIME_W-1:0]   intv;
   logic [DIST_W-1:0]   speed_res;
   logic [DIV_W-1:0]    speed_num;
   logic [KW-1:0]       rd_addr;
   logic [KW-1:0]       wr_addr;
   logic [RW-1:0]       wr_data;

   // divider hookup
   div_ctl_type      div_ctl;
   logic [DIV_W-1:0] div_dividend;
   logic [DIV_W-1:0] div_divisor;
   logic             div_done;
   logic [DIV_W-1:0] div_q;

   hkv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // configuration port
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         press_ff   <= PRESS_RESET;
         release_ff <= RELEASE_RESET;
      end else if (psel && penable && pwrite) begin
         case (paddr[ADDR_W-1])
            REG_PRESS:   press_ff   <= pwdata[CFG_W-1:0];
            REG_RELEASE: release_ff <= pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[ADDR_W-1])
         REG_PRESS:   prdata = DATA_W'(press_ff);
         REG_RELEASE: prdata = DATA_W'(release_ff);
         default:     prdata = '0;
      endcase
   end

   // request decode
   assign key_ok      = KEY_CMP_W'(req_chan.key) < KEY_CMP_W'(KEY_COUNT);
   assign frame_shift = req_ready && req_chan.valid && (req_chan.kind == KIND_FRAME);
   assign capture     = req_ready && req_chan.valid && key_ok &&
                        ((req_chan.kind == KIND_SAMPLE) || (req_chan.kind == KIND_LOAD));
   assign rd_addr     = KW'(req_chan.key);
   assign wr_addr     = KW'(key_ff);
   assign req_chan.ready = req_ready;

   // frame time shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         now_time_ff <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) past_ff[i] <= '0;
      end else if (frame_shift) begin
         now_time_ff <= req_chan.timestamp;
         past_ff[0]  <= now_time_ff;
         for (int i = 1; i < HISTORY_DEPTH; i++) past_ff[i] <= past_ff[i-1];
      end
   end

   // latch request fields
   always_ff @(posedge clock) begin
      if (capture) begin
         key_ff       <= req_chan.key;
         is_load_ff   <= (req_chan.kind == KIND_LOAD);
         sample_ff    <= req_chan.sample_value;
         center_ld_ff <= req_chan.center_value;
         gain_ld_ff   <= req_chan.field_gain;
      end
   end

   // key record store, registered read
   always_ff @(posedge clock) begin
      if (capture) begin
         mem_q_ff     <= mem[rd_addr];
         row_valid_ff <= key_valid_ff[rd_addr];
      end
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_valid_ff <= '0;
      end else if (mem_we) begin
         key_valid_ff[wr_addr] <= 1'b1;
      end
   end

   // record fields, unwritten keys read as zero
   assign row         = row_valid_ff ? mem_q_ff : '0;
   assign row_pressed = row[RW-1];
   assign row_center  = row[RW-2 -: CENTER_W];
   assign row_gain    = row[RW-2-CENTER_W -: GAIN_W];
   assign row_speed   = row[RW-2-CENTER_W-GAIN_W -: DIST_W];
   assign row_hist    = row[HW-1:0];
   assign oldest      = row_hist[HW-1 -: DIST_W];

   // offset and distance numerator
   assign diff      = $signed({3'b000, sample_ff}) - $signed({row_center[CENTER_W-1], row_center});
   assign offset    = diff[CENTER_W] ? OFFSET_W'(-diff) : OFFSET_W'(diff);
   assign gain_prod = PROD_W'(row_gain) * GAIN_SCALE;
   assign dist_q    = zero_ff ? DIST_MAX : div_q[DIST_W-1:0];

   // hysteresis and distance change
   assign event_now = row_pressed ? (dist_ff >= release_ff) : (dist_ff <= press_ff);
   assign delta_now = (dist_ff >= oldest) ? (dist_ff - oldest) : (oldest - dist_ff);

   // analog level: (d-100)*255/400 as ((x*256-x)/16)/25 by reciprocal
   assign level_x = dist_ff - LEVEL_BASE;
   assign level_y = {level_x[LEVEL_X_W-1:0], {LEVEL_W{1'b0}}} -
                    LEVEL_Y_W'(level_x[LEVEL_X_W-1:0]);
   assign level_z = level_y[LEVEL_Y_W-1:LEVEL_PRE];
   assign level_p = LEVEL_P_W'(level_z) * RECIP_25;

   always_comb begin
      if (dist_ff < LEVEL_BASE) begin
         level_now = '0;
      end else if (level_x >= LEVEL_SAT) begin
         level_now = LEVEL_MAX;
      end else begin
         level_now = level_p[RECIP_SHIFT +: LEVEL_W];
      end
   end

   // frame interval and speed
   assign intv      = now_time_ff - past_ff[HISTORY_DEPTH-1];
   assign speed_num = DIV_W'(delta_ff) * SPEED_SCALE;
   assign speed_res = intv_zero_ff ? DIST_MAX :
                      intv_big_ff  ? '0 : div_q[DIST_W-1:0];

   // divider operands
   always_comb begin
      if (state_ff == ST_FETCH) begin
         div_dividend = {gain_prod, {DIST_PAD{1'b0}}};
         div_divisor  = DIV_W'(offset);
      end else begin
         div_dividend = speed_num;
         div_divisor  = intv_lo_ff;
      end
   end

   // record write data: baseline load or end of sample
   always_comb begin
      if (state_ff == ST_FETCH) begin
         wr_data = {row_pressed, center_ld_ff, gain_ld_ff, row_speed, row_hist};
      end else begin
         wr_data = {pressed_new_ff, row_center, row_gain, speed_ff,
                    HW'({row_hist, dist_ff})};
      end
   end

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequencer next state and controls
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      div_ctl   = '0;
      mem_we    = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (capture) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            if (is_load_ff) begin
               mem_we   = 1'b1;
               state_in = ST_IDLE;
            end else begin
               div_ctl.start  = 1'b1;
               div_ctl.digits = DIGITS_DIST;
               state_in       = ST_DIST;
            end
         end
         ST_DIST: begin
            if (div_done) state_in = ST_JUDGE;
         end
         ST_JUDGE: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            if (event_ff) begin
               div_ctl.start  = 1'b1;
               div_ctl.digits = DIGITS_SPEED;
               state_in       = ST_SPEED;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SPEED: begin
            if (div_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               mem_we   = 1'b1;
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sample datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_FETCH: begin
            zero_ff <= (offset == '0);
         end
         ST_DIST: begin
            if (div_done) dist_ff <= dist_q;
         end
         ST_JUDGE: begin
            event_ff       <= event_now;
            pressed_new_ff <= row_pressed ^ event_now;
            delta_ff       <= delta_now;
            level_ff       <= level_now;
            intv_zero_ff   <= (intv == '0);
            intv_big_ff    <= |intv[TIME_W-1:DIV_W];
            intv_lo_ff     <= intv[DIV_W-1:0];
         end
         ST_PREP: begin
            if (!event_ff) speed_ff <= row_speed;
         end
         ST_SPEED: begin
            if (div_done) speed_ff <= speed_res;
         end
         default: ;
      endcase
   end

   // response output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_key_ff    <= key_ff;
         is_pressed_ff <= pressed_new_ff;
         event_res_ff  <= event_ff;
         speed_out_ff  <= speed_ff;
         dist_out_ff   <= dist_ff;
         level_out_ff  <= level_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_key      = out_key_ff;
   assign rsp_chan.is_pressed   = is_pressed_ff;
   assign rsp_chan.event_res    = event_res_ff;
   assign rsp_chan.speed        = speed_out_ff;
   assign rsp_chan.distance     = dist_out_ff;
   assign rsp_chan.analog_level = level_out_ff;

   // divider finishes only where the sequencer waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIST || state_ff == ST_SPEED))
      else $error("divider finished outside a wait state");

   // velocity division runs only after a press or release
   a_speed_on_event: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPEED) |-> event_ff)
      else $error("velocity computed without an event");

   // a finished sample holds while the previous response is still waiting
   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_chan.ready)
         |=> (state_ff == ST_FINISH && $stable(dist_ff)))
      else $error("sample left its last step while the response stalled");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Hall key velocity tracker. A directed table
// covers the zero offset, zero interval, truncation and clamp cases, then
// random frame, sample and baseline traffic runs under several threshold
// settings with random stalls on both channels. Every response is checked
// field by field against its typed table row or a cycle-free bench tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import hkv_pkg::*;

   localparam int KEYS  = 32;
   localparam int DEPTH = 3;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 185;
   localparam int SETTLE      = 60;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [KIND_W-1:0]          kind;
      logic [KEY_W-1:0]           key;
      logic [SAMPLE_W-1:0]        sample_value;
      logic [TIME_W-1:0]          timestamp;
      logic signed [CENTER_W-1:0] center_value;
      logic [GAIN_W-1:0]          field_gain;
   } key_request_t;

   typedef struct packed {
      logic [KEY_W-1:0]   out_key;
      logic               is_pressed;
      logic               event_res;
      logic [DIST_W-1:0]  speed;
      logic [DIST_W-1:0]  distance;
      logic [LEVEL_W-1:0] analog_level;
   } key_report_t;

   typedef struct packed {
      key_request_t req;
      logic         typed;
      key_report_t  exp;
   } table_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel, penable, pwrite, pready;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata, prdata;

   hkv_req_intf req_chan ();
   hkv_rsp_intf rsp_chan ();

   hall_key_velocity_tracker u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // tracker state kept by the bench
   logic [DIST_W-1:0]          press_level;
   logic [DIST_W-1:0]          release_level;
   logic [TIME_W-1:0]          frame_now;
   logic [TIME_W-1:0]          frame_past [0:DEPTH-1];
   logic [DIST_W-1:0]          dist_hist  [0:KEYS-1][0:DEPTH-1];
   logic                       key_down   [0:KEYS-1];
   logic [DIST_W-1:0]          key_speed  [0:KEYS-1];
   logic signed [CENTER_W-1:0] key_zero   [0:KEYS-1];
   logic [GAIN_W-1:0]          key_coef   [0:KEYS-1];

   key_report_t pending_reports [$];
   table_row_t  directed_rows [$];

   int unsigned mismatches = 0;
   int unsigned samples_seen = 0, events_seen = 0, frames_seen = 0;
   int unsigned loads_seen = 0, dropped_seen = 0, settings_seen = 0;
   int unsigned responses_seen = 0, holds_done = 0;
   bit gaps_enabled = 1'b1;
   bit stalls_enabled = 1'b1;
   bit hold_request = 1'b0;

   // one line per mismatch
   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   // apply one accepted request to the tracker, give its response if any
   task automatic track_key_request(input key_request_t r, output bit has_report,
                                    output key_report_t o);
      int            diff;
      int unsigned   span;
      logic [31:0]   quotient;
      logic [63:0]   delta, gap, ratio;
      logic [DIST_W-1:0] dist_now, old;
      logic [31:0]   lvl;
      bit            flip;
      int            k;
      has_report = 1'b0;
      o = '0;
      k = int'(r.key);
      case (r.kind)
         KIND_FRAME: begin
            for (int i = DEPTH - 1; i > 0; i--) frame_past[i] = frame_past[i-1];
            frame_past[0] = frame_now;
            frame_now = r.timestamp;
            frames_seen++;
         end
         KIND_LOAD: begin
            key_zero[k] = r.center_value;
            key_coef[k] = r.field_gain;
            loads_seen++;
         end
         KIND_SAMPLE: begin
            // distance from offset to the key's zero-field reading
            diff = int'(r.sample_value) - int'(key_zero[k]);
            span = (diff < 0) ? -diff : diff;
            if (span == 0) begin
               dist_now = DIST_MAX;
            end else begin
               quotient = (32'(key_coef[k]) * 32'd100) / span;
               dist_now = quotient[DIST_W-1:0];
            end
            // press and release hysteresis
            flip = 1'b0;
            if (key_down[k]) begin
               if (dist_now >= release_level) begin
                  key_down[k] = 1'b0;
                  flip = 1'b1;
               end
            end else if (dist_now <= press_level) begin
               key_down[k] = 1'b1;
               flip = 1'b1;
            end
            // velocity over the frame history on an event
            if (flip) begin
               old = dist_hist[k][DEPTH-1];
               delta = (dist_now >= old) ? 64'(dist_now - old) : 64'(old - dist_now);
               gap = frame_now - frame_past[DEPTH-1];
               if (gap == 64'd0) begin
                  key_speed[k] = DIST_MAX;
               end else begin
                  ratio = (delta * 64'd1000) / gap;
                  key_speed[k] = ratio[DIST_W-1:0];
               end
               events_seen++;
            end
            for (int i = DEPTH - 1; i > 0; i--) dist_hist[k][i] = dist_hist[k][i-1];
            dist_hist[k][0] = dist_now;
            // analog level, clamped
            if (dist_now < 16'd100) begin
               lvl = 0;
            end else begin
               lvl = ((32'(dist_now) - 32'd100) * 32'd255) / 32'd400;
               if (lvl > 32'd255) lvl = 32'd255;
            end
            o.out_key      = r.key;
            o.is_pressed   = key_down[k];
            o.event_res    = flip;
            o.speed        = key_speed[k];
            o.distance     = dist_now;
            o.analog_level = lvl[LEVEL_W-1:0];
            has_report = 1'b1;
            samples_seen++;
         end
         default: dropped_seen++;
      endcase
   endtask

   function automatic key_request_t make_request(
         input logic [KIND_W-1:0] kind, input int key, input int sample,
         input logic [TIME_W-1:0] stamp, input int center, input int gain);
      key_request_t r;
      r.kind         = kind;
      r.key          = KEY_W'(key);
      r.sample_value = SAMPLE_W'(sample);
      r.timestamp    = stamp;
      r.center_value = CENTER_W'(center);
      r.field_gain   = GAIN_W'(gain);
      return r;
   endfunction

   function automatic key_report_t make_report(input int key, input bit down,
         input bit flip, input int spd, input int dist_val, input int lvl);
      key_report_t o;
      o.out_key      = KEY_W'(key);
      o.is_pressed   = down;
      o.event_res    = flip;
      o.speed        = DIST_W'(spd);
      o.distance     = DIST_W'(dist_val);
      o.analog_level = LEVEL_W'(lvl);
      return o;
   endfunction

   task automatic add_row(input key_request_t r, input bit typed, input key_report_t e);
      table_row_t row;
      row.req   = r;
      row.typed = typed;
      row.exp   = e;
      directed_rows.push_back(row);
   endtask

   // offer one request and wait for it to be taken
   task automatic offer_request(input key_request_t r, input bit typed,
                                input key_report_t e);
      bit          has_report;
      key_report_t predicted;
      req_chan.valid        <= 1'b1;
      req_chan.kind         <= r.kind;
      req_chan.key          <= r.key;
      req_chan.sample_value <= r.sample_value;
      req_chan.timestamp    <= r.timestamp;
      req_chan.center_value <= r.center_value;
      req_chan.field_gain   <= r.field_gain;
      do @(posedge clock); while (!req_chan.ready);
      track_key_request(r, has_report, predicted);
      if (typed) pending_reports.push_back(e);
      else if (has_report) pending_reports.push_back(predicted);
   endtask

   // stop offering until all responses are back and the block has settled
   task automatic drain_requests();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_reports.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // one register access: setup cycle, then access until pready
   task automatic csr_access(input bit write_en, input logic reg_sel,
                             input logic [DATA_W-1:0] wdata,
                             output logic [DATA_W-1:0] rdata);
      psel    <= 1'b1;
      pwrite  <= write_en;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_thresholds();
      logic [DATA_W-1:0] value;
      csr_access(1'b0, REG_PRESS, '0, value);
      if (value !== {16'd0, press_level})
         report_mismatch($sformatf("press threshold read %0d expected %0d",
                                   value, press_level));
      csr_access(1'b0, REG_RELEASE, '0, value);
      if (value !== {16'd0, release_level})
         report_mismatch($sformatf("release threshold read %0d expected %0d",
                                   value, release_level));
   endtask

   // upper data bits are junk, the registers keep only the low half
   task automatic set_thresholds(input logic [DIST_W-1:0] press,
                                 input logic [DIST_W-1:0] rel);
      logic [DATA_W-1:0] unused;
      csr_access(1'b1, REG_PRESS, {16'($urandom), press}, unused);
      press_level = press;
      csr_access(1'b1, REG_RELEASE, {16'($urandom), rel}, unused);
      release_level = rel;
      settings_seen++;
      check_thresholds();
   endtask

   // random request: mostly samples near each key's center, some frames,
   // baseline loads and a few requests of the unused kind
   logic [TIME_W-1:0] stamp_base = '0;

   task automatic draw_request(output key_request_t r, output bit dropped);
      int pick, c, off, rd, k;
      pick = $urandom_range(0, 99);
      r.kind         = KIND_SAMPLE;
      r.key          = KEY_W'($urandom);
      r.sample_value = SAMPLE_W'($urandom);
      r.timestamp    = {$urandom, $urandom};
      r.center_value = CENTER_W'($urandom);
      r.field_gain   = GAIN_W'($urandom);
      dropped = 1'b0;
      if (pick < 15) begin
         r.kind = KIND_FRAME;
         pick = $urandom_range(0, 9);
         if (pick < 7) stamp_base = stamp_base + 64'($urandom_range(1, 3000));
         else if (pick == 8) stamp_base = {$urandom, $urandom};
         else if (pick == 9) stamp_base = stamp_base + {$urandom, $urandom};
         r.timestamp = stamp_base;
      end else if (pick < 25) begin
         r.kind = KIND_LOAD;
         if ($urandom_range(0, 4) != 0) r.center_value = CENTER_W'($urandom_range(0, 4095));
         pick = $urandom_range(0, 19);
         if (pick < 12) r.field_gain = GAIN_W'($urandom_range(0, 1500));
         else if (pick < 15) r.field_gain = GAIN_W'($urandom_range(0, 20));
      end else if (pick < 30) begin
         r.kind = KIND_UNUSED;
         dropped = 1'b1;
      end else begin
         if ($urandom_range(0, 1) == 0) r.key = KEY_W'($urandom_range(0, 7));
         k = int'(r.key);
         if ($urandom_range(0, 3) != 0) begin
            c = int'(key_zero[k]);
            off = $urandom_range(0, int'(key_coef[k]) + 4);
            rd = ($urandom_range(0, 1) == 0) ? c + off : c - off;
            if (rd < 0) rd = 0;
            if (rd > 4095) rd = 4095;
            r.sample_value = SAMPLE_W'(rd);
         end
      end
   endtask

   // response side: random stalls, one long hold on request, checking
   task automatic check_report();
      key_report_t want;
      responses_seen++;
      if (pending_reports.size() == 0) begin
         report_mismatch($sformatf("response for key %0d with none pending",
                                   rsp_chan.out_key));
      end else begin
         want = pending_reports.pop_front();
         if (rsp_chan.out_key !== want.out_key)
            report_mismatch($sformatf("response %0d key got %0d expected %0d",
                            responses_seen, rsp_chan.out_key, want.out_key));
         if (rsp_chan.is_pressed !== want.is_pressed)
            report_mismatch($sformatf("response %0d is_pressed got %0d expected %0d",
                            responses_seen, rsp_chan.is_pressed, want.is_pressed));
         if (rsp_chan.event_res !== want.event_res)
            report_mismatch($sformatf("response %0d event_res got %0d expected %0d",
                            responses_seen, rsp_chan.event_res, want.event_res));
         if (rsp_chan.speed !== want.speed)
            report_mismatch($sformatf("response %0d speed got %0d expected %0d",
                            responses_seen, rsp_chan.speed, want.speed));
         if (rsp_chan.distance !== want.distance)
            report_mismatch($sformatf("response %0d distance got %0d expected %0d",
                            responses_seen, rsp_chan.distance, want.distance));
         if (rsp_chan.analog_level !== want.analog_level)
            report_mismatch($sformatf("response %0d analog_level got %0d expected %0d",
                            responses_seen, rsp_chan.analog_level, want.analog_level));
      end
   endtask

   initial begin : response_side
      int unsigned stall_left, hold_left, cycle_count;
      stall_left = 0;
      hold_left = 0;
      cycle_count = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (!reset && rsp_chan.valid && rsp_chan.ready) check_report();
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            holds_done++;
         end
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stalls_enabled && (cycle_count % 1000) < 700 &&
                      $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin
      #4000000;
      $display("simulation failed");
      $finish;
   end

   // main sequence
   initial begin : request_side
      key_request_t r;
      key_report_t  none;
      bit           dropped;
      int unsigned  n;
      logic [DIST_W-1:0] press_set [0:PHASES-1];
      logic [DIST_W-1:0] release_set [0:PHASES-1];

      none = '0;
      req_chan.valid        <= 1'b0;
      req_chan.kind         <= KIND_FRAME;
      req_chan.key          <= '0;
      req_chan.sample_value <= '0;
      req_chan.timestamp    <= '0;
      req_chan.center_value <= '0;
      req_chan.field_gain   <= '0;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;

      // tracker state after reset
      press_level   = PRESS_RESET;
      release_level = RELEASE_RESET;
      frame_now = '0;
      for (int i = 0; i < DEPTH; i++) frame_past[i] = '0;
      for (int k = 0; k < KEYS; k++) begin
         key_down[k]  = 1'b0;
         key_speed[k] = '0;
         key_zero[k]  = '0;
         key_coef[k]  = '0;
         for (int i = 0; i < DEPTH; i++) dist_hist[k][i] = '0;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_thresholds();

      // directed table; typed rows are read straight off the defaults
      add_row(make_request(KIND_SAMPLE, 0, 0, 0, 0, 0), 1,
              make_report(0, 0, 0, 0, 65535, 255));
      add_row(make_request(KIND_SAMPLE, 1, 5, 0, 0, 0), 1,
              make_report(1, 1, 1, 65535, 0, 0));
      add_row(make_request(KIND_SAMPLE, 1, 5, 0, 0, 0), 1,
              make_report(1, 1, 0, 65535, 0, 0));
      add_row(make_request(KIND_UNUSED, 7, 4095, '1, -1, 8191), 0, none);
      add_row(make_request(KIND_FRAME, 0, 0, 64'd1000, 0, 0), 0, none);
      add_row(make_request(KIND_FRAME, 0, 0, 64'd2000, 0, 0), 0, none);
      add_row(make_request(KIND_FRAME, 0, 0, 64'd3000, 0, 0), 0, none);
      add_row(make_request(KIND_FRAME, 0, 0, 64'd4000, 0, 0), 0, none);
      add_row(make_request(KIND_LOAD, 2, 0, 0, 2048, 8191), 0, none);
      add_row(make_request(KIND_SAMPLE, 2, 2047, 0, 0, 0), 1,
              make_report(2, 0, 0, 0, 32668, 255));
      add_row(make_request(KIND_LOAD, 3, 0, 0, -8192, 0), 0, none);
      add_row(make_request(KIND_SAMPLE, 3, 4095, 0, 0, 0), 1,
              make_report(3, 1, 1, 0, 0, 0));
      add_row(make_request(KIND_LOAD, 4, 0, 0, 8191, 8191), 0, none);
      add_row(make_request(KIND_SAMPLE, 4, 0, 0, 0, 0), 1,
              make_report(4, 1, 1, 33, 100, 0));
      add_row(make_request(KIND_SAMPLE, 4, 4095, 0, 0, 0), 0, none);
      add_row(make_request(KIND_LOAD, 5, 0, 0, 0, 5), 0, none);
      add_row(make_request(KIND_SAMPLE, 5, 1, 0, 0, 0), 0, none);
      add_row(make_request(KIND_SAMPLE, 5, 2, 0, 0, 0), 0, none);
      add_row(make_request(KIND_SAMPLE, 5, 1, 0, 0, 0), 0, none);
      add_row(make_request(KIND_LOAD, 6, 0, 0, 0, 99), 0, none);
      add_row(make_request(KIND_SAMPLE, 6, 100, 0, 0, 0), 0, none);
      add_row(make_request(KIND_FRAME, 0, 0, '1, 0, 0), 0, none);
      add_row(make_request(KIND_FRAME, 0, 0, 64'd0, 0, 0), 0, none);
      add_row(make_request(KIND_SAMPLE, 6, 0, 0, 0, 0), 0, none);
      add_row(make_request(KIND_SAMPLE, 31, 4095, 0, 0, 0), 0, none);
      foreach (directed_rows[i])
         offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].exp);
      drain_requests();

      // threshold settings per random phase, extremes among them
      press_set[0] = 16'd250;   release_set[0] = 16'd300;
      press_set[1] = 16'd0;     release_set[1] = 16'd0;
      press_set[2] = 16'hFFFF;  release_set[2] = 16'd0;
      press_set[3] = 16'hFFFF;  release_set[3] = 16'hFFFF;
      press_set[4] = 16'($urandom_range(0, 2000));
      release_set[4] = 16'($urandom_range(0, 2000));
      press_set[5] = 16'd0;     release_set[5] = 16'hFFFF;
      press_set[6] = 16'($urandom);
      release_set[6] = 16'($urandom);
      press_set[7] = 16'd250;   release_set[7] = 16'd300;

      // give every key a baseline before random traffic
      for (int k = 0; k < KEYS; k++)
         offer_request(make_request(KIND_LOAD, k, $urandom, {$urandom, $urandom},
                       $urandom_range(0, 4095), $urandom_range(0, 1500)), 0, none);
      drain_requests();

      for (int p = 0; p < PHASES; p++) begin
         set_thresholds(press_set[p], release_set[p]);
         if (p == PHASES - 1) begin
            gaps_enabled   = 1'b0;
            stalls_enabled = 1'b0;
         end
         // one phase holds the response side off while requests keep coming
         if (p == 2) hold_request = 1'b1;
         n = 0;
         while (n < PHASE_ITEMS) begin
            if (gaps_enabled && (n % 200) >= 60 && $urandom_range(0, 5) == 0) begin
               req_chan.valid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end
            draw_request(r, dropped);
            offer_request(r, 1'b0, none);
            if (!dropped) n++;
         end
         drain_requests();
      end

      if (pending_reports.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", pending_reports.size()));
      $display("covered %0d samples with %0d press/release events, %0d frame ticks,",
               samples_seen, events_seen, frames_seen);
      $display("%0d baseline loads, %0d dropped requests, %0d threshold settings, %0d long holds",
               loads_seen, dropped_seen, settings_seen, holds_done);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
